### rtl/assert_macros.svh
// Assertion helpers shared by the RTL of the sorted table block.
// Clocked concurrent checks, with or without a reset qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is asserted.
`define STID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check that also holds during reset.
`define STID_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/stid_pkg.sv
// Shared types and codes for the sorted table block.
// No dependencies.
package stid_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_MIN_RD,
        S_MIN_WAIT
    } t_state;

    typedef logic [1:0] t_status;

    localparam t_status ST_INSERTED = 2'd0;
    localparam t_status ST_DELETED  = 2'd1;
    localparam t_status ST_MISSING  = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

endpackage

### rtl/stid_if.sv
// Request and response channel interfaces of the sorted table block.
// Depends on stid_pkg for field widths.
interface stid_req_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic signed [stid_pkg::VALUE_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface stid_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic [stid_pkg::COUNT_W-1:0]        entry_count;
    logic signed [stid_pkg::VALUE_W-1:0] smallest;

    modport source (output valid, output status, output entry_count, output smallest,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input smallest,
                    output ready);
endinterface

### rtl/stid_store.sv
// Entry store of the sorted table: one write port, one registered read port.
// Depends on stid_pkg for the entry width.
module stid_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [AW-1:0]                       i_waddr,
    input  logic signed [stid_pkg::VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]                       i_raddr,
    output logic signed [stid_pkg::VALUE_W-1:0] o_rdata
);
    import stid_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sorted_table_insert_delete.sv
// Sorted table of signed 32-bit values with ordered insert and first-match delete.
// One transaction at a time: the request side stays not ready until the result is queued,
// so a new request is taken only after the result register has loaded.
// A single compare unit and the one write port and one read port of the entry store bound the rate.
// Synchronous active-low reset empties the table; stored values are not cleared.
`include "assert_macros.svh"

module sorted_table_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stid_req_if.sink   i_req,
    stid_rsp_if.source o_rsp
);
    import stid_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    t_state                    r_state, n_state;
    logic                      r_action;
    logic signed [VALUE_W-1:0] r_value;
    logic [CW-1:0]             r_idx, n_idx;
    logic [CW-1:0]             r_k, n_k;
    logic [CW-1:0]             r_count, n_count;
    t_status                   r_status, n_status;
    logic                      r_out_valid, n_out_valid;
    t_status                   r_out_status;
    logic [COUNT_W-1:0]        r_out_count;
    logic signed [VALUE_W-1:0] r_out_smallest;

    logic                      req_acc;
    logic                      out_free;
    logic                      out_load;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic signed [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]             mem_raddr;
    logic signed [VALUE_W-1:0] mem_rdata;
    logic                      cmp_lt, cmp_eq;
    logic [CW-1:0]             k_dec;
    logic [CW:0]               k_inc;
    logic                      is_ins;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign is_ins      = (r_action == ACT_INSERT);

    // the shared compare unit
    assign cmp_lt = (mem_rdata < r_value);
    assign cmp_eq = (mem_rdata == r_value);
    assign k_dec  = r_k - 1'b1;
    assign k_inc  = {1'b0, r_k} + 1'b1;

    stid_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.action == ACT_INSERT && r_count == CAP) n_state = S_MIN_RD;
                    else n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (r_idx >= r_count) n_state = is_ins ? S_SHIFT_RD : S_MIN_RD;
                else n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (is_ins) n_state = cmp_lt ? S_SCAN_RD : S_SHIFT_RD;
                else n_state = cmp_eq ? S_SHIFT_RD : S_SCAN_RD;
            end
            S_SHIFT_RD: begin
                if (is_ins) n_state = (r_k > r_idx) ? S_SHIFT_WR : S_MIN_RD;
                else n_state = (k_inc < {1'b0, r_count}) ? S_SHIFT_WR : S_MIN_RD;
            end
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_MIN_RD:   n_state = S_MIN_WAIT;
            S_MIN_WAIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and store controls
    always_comb begin
        n_idx       = r_idx;
        n_k         = r_k;
        n_count     = r_count;
        n_status    = r_status;
        n_out_valid = r_out_valid && !o_rsp.ready;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_k[AW-1:0];
        mem_wdata   = mem_rdata;
        mem_raddr   = '0;
        unique case (r_state)
            S_IDLE: begin
                n_idx    = '0;
                n_status = ST_FULL;
            end
            S_SCAN_RD: begin
                mem_raddr = r_idx[AW-1:0];
                if (r_idx >= r_count) begin
                    n_k      = r_count;
                    n_status = ST_MISSING;
                end
            end
            S_SCAN_CMP: begin
                if (is_ins) begin
                    if (cmp_lt) n_idx = r_idx + 1'b1;
                    else n_k = r_count;
                end else begin
                    if (cmp_eq) n_k = r_idx;
                    else n_idx = r_idx + 1'b1;
                end
            end
            S_SHIFT_RD: begin
                if (is_ins) begin
                    mem_raddr = k_dec[AW-1:0];
                    if (!(r_k > r_idx)) begin
                        // gap is open: drop the new value in
                        mem_we    = 1'b1;
                        mem_waddr = r_idx[AW-1:0];
                        mem_wdata = r_value;
                        n_count   = r_count + 1'b1;
                        n_status  = ST_INSERTED;
                    end
                end else begin
                    mem_raddr = k_inc[AW-1:0];
                    if (!(k_inc < {1'b0, r_count})) begin
                        n_count  = r_count - 1'b1;
                        n_status = ST_DELETED;
                    end
                end
            end
            S_SHIFT_WR: begin
                mem_we = 1'b1;
                n_k    = is_ins ? k_dec : k_inc[CW-1:0];
            end
            S_MIN_RD: begin
                mem_raddr = '0;
            end
            S_MIN_WAIT: begin
                mem_raddr = '0;
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                mem_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_action <= i_req.action;
            r_value  <= i_req.value;
        end
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_status <= n_status;
        if (out_load) begin
            r_out_status   <= r_status;
            r_out_count    <= COUNT_W'(r_count);
            r_out_smallest <= (r_count != '0) ? mem_rdata : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.smallest    = r_out_smallest;

    `STID_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CAP, "entry count above capacity")
    `STID_ASSERT(a_write_in_range, i_clk, i_rst_n, mem_we |-> (r_k < CAP && r_idx < CAP),
        "store write outside the table")
    `STID_ASSERT(a_busy_after_req, i_clk, i_rst_n, req_acc |=> !i_req.ready,
        "ready again straight after a transaction")
    `STID_ASSERT(a_full_status, i_clk, i_rst_n,
        (r_state == S_MIN_WAIT && r_status == ST_FULL) |-> (r_count == CAP),
        "full status with room left")
    `STID_ASSERT(a_shift_order, i_clk, i_rst_n,
        (r_state == S_SHIFT_WR) |-> ($past(r_state) == S_SHIFT_RD),
        "entry move without a preceding read")

endmodule
